### sv/gae_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gae_pkg
// Shared widths, constants, item types and the arctangent table for the
// gradient axis endpoint pipeline.
// ----------------------------------------------------------------------------
package gae_pkg;

  // Angle format and quarter-turn reduction
  localparam int ANGLE_FRAC_BITS = 8;
  localparam int CORDIC_ZBITS    = 20;
  localparam int ZSHIFT          = CORDIC_ZBITS - ANGLE_FRAC_BITS;
  localparam int QUARTER         = 90 << ANGLE_FRAC_BITS;
  localparam int MAG_W           = 24;
  localparam int REM_W           = $clog2(QUARTER);
  localparam int RED_STAGES      = 3;
  localparam int RED_PER_STAGE   = 3;
  localparam int RED_STEPS       = RED_STAGES * RED_PER_STAGE;

  // CORDIC
  localparam int CORDIC_STEPS    = 20;
  localparam int Z_W             = 28;
  localparam int XY_W            = 33;
  localparam longint CORDIC_START = 652032875;
  localparam longint UNIT_ONE     = 64'd1 << 30;
  localparam int SC_W            = 31;

  // Products and tangent offset division
  localparam int PROD_W          = 50;
  localparam int NUM_W           = 52;
  localparam int DEN2_W          = 32;
  localparam int DIV_BITS        = 24;
  localparam int CMP_W           = NUM_W + 4;
  localparam longint OFF_CAP     = 64'd1 << 23;

  // Coordinates
  localparam int OUT_W           = 21;

  typedef struct packed {
    logic signed [19:0] left;
    logic signed [19:0] top;
    logic        [18:0] w;
    logic        [18:0] h;
    logic               neg;
    logic        [1:0]  q;
    logic               below;
  } side_t;

  typedef struct packed {
    logic signed [OUT_W-1:0] end_y;
    logic signed [OUT_W-1:0] end_x;
    logic signed [OUT_W-1:0] start_y;
    logic signed [OUT_W-1:0] start_x;
  } res_t;

  // atan(2^-i) in 2^-20 degree
  function automatic logic signed [Z_W-1:0] atan_val(input int i);
    logic signed [Z_W-1:0] v;
    case (i)
      0:  v = 28'sd47185920;
      1:  v = 28'sd27855475;
      2:  v = 28'sd14718068;
      3:  v = 28'sd7471121;
      4:  v = 28'sd3750058;
      5:  v = 28'sd1876857;
      6:  v = 28'sd938658;
      7:  v = 28'sd469357;
      8:  v = 28'sd234682;
      9:  v = 28'sd117342;
      10: v = 28'sd58671;
      11: v = 28'sd29335;
      12: v = 28'sd14668;
      13: v = 28'sd7334;
      14: v = 28'sd3667;
      15: v = 28'sd1833;
      16: v = 28'sd917;
      17: v = 28'sd458;
      18: v = 28'sd229;
      19: v = 28'sd115;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

### sv/gae_reduce.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gae_reduce
// Takes the angle magnitude apart into quarter index and remainder by
// restoring compare-subtract against shifted quarter turns, three per stage.
// ----------------------------------------------------------------------------
module gae_reduce (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          ce,
  input  logic                          in_v,
  input  logic signed [23:0]            in_ang,
  input  gae_pkg::side_t                in_side,
  output logic                          out_v,
  output logic [gae_pkg::REM_W-1:0]     out_rem,
  output gae_pkg::side_t                out_side
);

  localparam int NS = gae_pkg::RED_STAGES + 1;

  logic                       v_r    [NS];
  logic [gae_pkg::MAG_W-1:0]  rem_r  [NS];
  logic [1:0]                 q_r    [NS];
  gae_pkg::side_t             side_r [NS];
  logic [gae_pkg::MAG_W-1:0]  mag_nxt;

  // Take the magnitude of the angle
  always_comb begin
    mag_nxt = in_ang[23] ? (~in_ang + 24'd1) : in_ang;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r[0] <= 1'b0;
    end else if (ce) begin
      v_r[0] <= in_v;
    end
    if (ce) begin
      rem_r[0]  <= mag_nxt;
      q_r[0]    <= 2'd0;
      side_r[0] <= in_side;
    end
  end

  for (genvar s = 0; s < gae_pkg::RED_STAGES; s++) begin : g_stage
    logic [gae_pkg::MAG_W-1:0] rem_nxt;
    logic [1:0]                q_nxt;

    // Subtract the shifted quarter where it fits, shift in the quotient bit
    always_comb begin
      logic [gae_pkg::MAG_W:0] lim;
      rem_nxt = rem_r[s];
      q_nxt   = q_r[s];
      for (int t = 0; t < gae_pkg::RED_PER_STAGE; t++) begin
        lim = (gae_pkg::MAG_W+1)'(gae_pkg::QUARTER) <<
              (gae_pkg::RED_STEPS - 1 - s * gae_pkg::RED_PER_STAGE - t);
        if ({1'b0, rem_nxt} >= lim) begin
          rem_nxt = rem_nxt - lim[gae_pkg::MAG_W-1:0];
          q_nxt   = {q_nxt[0], 1'b1};
        end else begin
          q_nxt   = {q_nxt[0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[s+1] <= 1'b0;
      end else if (ce) begin
        v_r[s+1] <= v_r[s];
      end
      if (ce) begin
        rem_r[s+1]  <= rem_nxt;
        q_r[s+1]    <= q_nxt;
        side_r[s+1] <= side_r[s];
      end
    end
  end

  always_comb begin
    out_v      = v_r[NS-1];
    out_rem    = rem_r[NS-1][gae_pkg::REM_W-1:0];
    out_side   = side_r[NS-1];
    out_side.q = q_r[NS-1];
  end

endmodule

### sv/gae_cordic.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gae_cordic
// Unrolled rotation-mode CORDIC, one micro-rotation per stage, giving
// cosine and sine of the in-quarter angle scaled by 2^30.
// ----------------------------------------------------------------------------
module gae_cordic (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              ce,
  input  logic                              in_v,
  input  logic [gae_pkg::REM_W-1:0]         in_rem,
  input  gae_pkg::side_t                    in_side,
  output logic                              out_v,
  output logic signed [gae_pkg::XY_W-1:0]   out_x,
  output logic signed [gae_pkg::XY_W-1:0]   out_y,
  output gae_pkg::side_t                    out_side
);

  localparam int NS = gae_pkg::CORDIC_STEPS + 1;

  logic                            v_r    [NS];
  logic signed [gae_pkg::XY_W-1:0] x_r    [NS];
  logic signed [gae_pkg::XY_W-1:0] y_r    [NS];
  logic signed [gae_pkg::Z_W-1:0]  z_r    [NS];
  gae_pkg::side_t                  side_r [NS];

  // Load the start vector and widen the angle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r[0] <= 1'b0;
    end else if (ce) begin
      v_r[0] <= in_v;
    end
    if (ce) begin
      x_r[0]    <= gae_pkg::XY_W'(gae_pkg::CORDIC_START);
      y_r[0]    <= '0;
      z_r[0]    <= signed'(gae_pkg::Z_W'(in_rem) << gae_pkg::ZSHIFT);
      side_r[0] <= in_side;
    end
  end

  for (genvar i = 0; i < gae_pkg::CORDIC_STEPS; i++) begin : g_step
    logic signed [gae_pkg::XY_W-1:0] xs, ys;
    assign xs = x_r[i] >>> i;
    assign ys = y_r[i] >>> i;

    // Rotate toward zero residual angle
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[i+1] <= 1'b0;
      end else if (ce) begin
        v_r[i+1] <= v_r[i];
      end
      if (ce) begin
        side_r[i+1] <= side_r[i];
        if (!z_r[i][gae_pkg::Z_W-1]) begin
          x_r[i+1] <= x_r[i] - ys;
          y_r[i+1] <= y_r[i] + xs;
          z_r[i+1] <= z_r[i] - gae_pkg::atan_val(i);
        end else begin
          x_r[i+1] <= x_r[i] + ys;
          y_r[i+1] <= y_r[i] - xs;
          z_r[i+1] <= z_r[i] + gae_pkg::atan_val(i);
        end
      end
    end
  end

  assign out_v    = v_r[NS-1];
  assign out_x    = x_r[NS-1];
  assign out_y    = y_r[NS-1];
  assign out_side = side_r[NS-1];

endmodule

### sv/gae_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gae_div
// Pipelined restoring divider for the tangent offset: round(p / den) capped
// at 2^23, one quotient bit per stage after an overflow precheck.
// ----------------------------------------------------------------------------
module gae_div (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               ce,
  input  logic                               in_v,
  input  logic [gae_pkg::PROD_W-1:0]         in_p,
  input  logic [gae_pkg::SC_W-1:0]           in_den,
  input  gae_pkg::side_t                     in_side,
  output logic                               out_v,
  output logic [gae_pkg::DIV_BITS-1:0]       out_d,
  output gae_pkg::side_t                     out_side
);

  localparam int NS = gae_pkg::DIV_BITS + 1;

  logic                               v_r    [NS];
  logic [gae_pkg::NUM_W-1:0]          rem_r  [NS];
  logic [gae_pkg::DIV_BITS-1:0]       quo_r  [NS];
  logic [gae_pkg::DEN2_W-1:0]         d2_r   [NS];
  logic                               cap_r  [NS];
  logic                               zero_r [NS];
  gae_pkg::side_t                     side_r [NS];

  logic [gae_pkg::NUM_W-1:0]  num_nxt;
  logic [gae_pkg::DEN2_W-1:0] d2_nxt;
  logic                       cap_nxt, zero_nxt;

  // Form 2p + den over 2den and flag quotients at or above 2^24
  always_comb begin
    num_nxt = {1'b0, in_p, 1'b0} + gae_pkg::NUM_W'(in_den);
    d2_nxt  = {in_den, 1'b0};
    if (in_den == '0) begin
      zero_nxt = (in_p == '0);
      cap_nxt  = (in_p != '0);
    end else begin
      zero_nxt = 1'b0;
      cap_nxt  = (num_nxt >> gae_pkg::DIV_BITS) >= gae_pkg::NUM_W'(d2_nxt);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r[0] <= 1'b0;
    end else if (ce) begin
      v_r[0] <= in_v;
    end
    if (ce) begin
      rem_r[0]  <= num_nxt;
      quo_r[0]  <= '0;
      d2_r[0]   <= d2_nxt;
      cap_r[0]  <= cap_nxt;
      zero_r[0] <= zero_nxt;
      side_r[0] <= in_side;
    end
  end

  for (genvar k = 0; k < gae_pkg::DIV_BITS; k++) begin : g_bit
    logic [gae_pkg::CMP_W-1:0] dsh;
    logic                      fit;
    assign dsh = gae_pkg::CMP_W'(d2_r[k]) << (gae_pkg::DIV_BITS - 1 - k);
    assign fit = gae_pkg::CMP_W'(rem_r[k]) >= dsh;

    // Subtract the shifted divisor where it fits
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k+1] <= 1'b0;
      end else if (ce) begin
        v_r[k+1] <= v_r[k];
      end
      if (ce) begin
        rem_r[k+1]  <= fit ? (rem_r[k] - dsh[gae_pkg::NUM_W-1:0]) : rem_r[k];
        quo_r[k+1]  <= {quo_r[k][gae_pkg::DIV_BITS-2:0], fit};
        d2_r[k+1]   <= d2_r[k];
        cap_r[k+1]  <= cap_r[k];
        zero_r[k+1] <= zero_r[k];
        side_r[k+1] <= side_r[k];
      end
    end
  end

  // Apply the zero divisor and cap cases
  always_comb begin
    if (zero_r[NS-1]) begin
      out_d = '0;
    end else if (cap_r[NS-1] ||
                 (64'(quo_r[NS-1]) > gae_pkg::OFF_CAP)) begin
      out_d = gae_pkg::DIV_BITS'(gae_pkg::OFF_CAP);
    end else begin
      out_d = quo_r[NS-1];
    end
  end

  assign out_v    = v_r[NS-1];
  assign out_side = side_r[NS-1];

endmodule

### sv/gradient_axis_endpoints.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gradient_axis_endpoints
// Endpoints of the line through a rectangle's center at a given angle,
// where it meets the rectangle's edges.
// ----------------------------------------------------------------------------
//  channel  direction  payload
//  in_*     slave      rect_left, rect_top, rect_width, rect_height, angle_deg
//  out_*    master     start_x, start_y, end_x, end_y
//
//  One item per cycle sustained while the skid stage stays empty; most of the
//  pipeline depth lies in the 24-stage quotient divider and 20-stage CORDIC.
//  Reset (rst_n low, synchronous) clears all valid bits.
//  A stall on out_tready freezes the pipeline once the one-item skid
//  stage behind the output register is full; nothing is lost or repeated.
// ----------------------------------------------------------------------------
module gradient_axis_endpoints (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // rect_left[19:0], rect_top[39:20], rect_width[58:40],
  // rect_height[77:59], angle_deg[101:78], zero pad[103:102]
  input  logic [103:0] in_tdata,
  output logic         out_tvalid,
  input  logic         out_tready,
  // start_x[20:0], start_y[41:21], end_x[62:42], end_y[83:63], zero pad[87:84]
  output logic [87:0]  out_tdata
);

  logic ce;

  // Unpack the input item
  gae_pkg::side_t in_side;
  always_comb begin
    in_side.left  = in_tdata[19:0];
    in_side.top   = in_tdata[39:20];
    in_side.w     = in_tdata[58:40];
    in_side.h     = in_tdata[77:59];
    in_side.neg   = in_tdata[101];
    in_side.q     = 2'd0;
    in_side.below = 1'b0;
  end

  // Quarter reduction
  logic                        red_v;
  logic [gae_pkg::REM_W-1:0]   red_rem;
  gae_pkg::side_t              red_side;

  gae_reduce u_reduce (
    .clk      (clk),
    .rst_n    (rst_n),
    .ce       (ce),
    .in_v     (in_tvalid & in_tready),
    .in_ang   (in_tdata[101:78]),
    .in_side  (in_side),
    .out_v    (red_v),
    .out_rem  (red_rem),
    .out_side (red_side)
  );

  // Cosine and sine
  logic                            cor_v;
  logic signed [gae_pkg::XY_W-1:0] cor_x, cor_y;
  gae_pkg::side_t                  cor_side;

  gae_cordic u_cordic (
    .clk      (clk),
    .rst_n    (rst_n),
    .ce       (ce),
    .in_v     (red_v),
    .in_rem   (red_rem),
    .in_side  (red_side),
    .out_v    (cor_v),
    .out_x    (cor_x),
    .out_y    (cor_y),
    .out_side (cor_side)
  );

  // Clamp c and s to 0..2^30
  logic                       m1_v_r;
  logic [gae_pkg::SC_W-1:0]   c1_r, s1_r;
  gae_pkg::side_t             m1_side_r;

  function automatic logic [gae_pkg::SC_W-1:0] clamp_unit(
    input logic signed [gae_pkg::XY_W-1:0] v);
    logic [gae_pkg::SC_W-1:0] r;
    if (v < 0) begin
      r = '0;
    end else if (64'(v) > gae_pkg::UNIT_ONE) begin
      r = gae_pkg::SC_W'(gae_pkg::UNIT_ONE);
    end else begin
      r = v[gae_pkg::SC_W-1:0];
    end
    return r;
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m1_v_r <= 1'b0;
    end else if (ce) begin
      m1_v_r <= cor_v;
    end
    if (ce) begin
      c1_r      <= clamp_unit(cor_x);
      s1_r      <= clamp_unit(cor_y);
      m1_side_r <= cor_side;
    end
  end

  // Cross products for the diagonal test
  logic                        m2_v_r;
  logic [gae_pkg::PROD_W-1:0]  sw_r, ch_r;
  logic [gae_pkg::SC_W-1:0]    c2_r, s2_r;
  gae_pkg::side_t              m2_side_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m2_v_r <= 1'b0;
    end else if (ce) begin
      m2_v_r <= m1_v_r;
    end
    if (ce) begin
      sw_r      <= gae_pkg::PROD_W'(s1_r) * gae_pkg::PROD_W'(m1_side_r.w);
      ch_r      <= gae_pkg::PROD_W'(c1_r) * gae_pkg::PROD_W'(m1_side_r.h);
      c2_r      <= c1_r;
      s2_r      <= s1_r;
      m2_side_r <= m1_side_r;
    end
  end

  // Pick region, multiplicand, numerator and divisor
  logic                       m3_v_r;
  logic [18:0]                mul3_r;
  logic [gae_pkg::SC_W-1:0]   num3_r, den3_r;
  gae_pkg::side_t             m3_side_r;
  gae_pkg::side_t             m3_side_nxt;
  logic                       below;

  assign below = sw_r < ch_r;

  // Record the diagonal decision with the item
  always_comb begin
    m3_side_nxt       = m2_side_r;
    m3_side_nxt.below = below;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m3_v_r <= 1'b0;
    end else if (ce) begin
      m3_v_r <= m2_v_r;
    end
    if (ce) begin
      mul3_r    <= ((!m2_side_r.q[0]) == below) ? m2_side_r.w : m2_side_r.h;
      num3_r    <= below ? s2_r : c2_r;
      den3_r    <= below ? c2_r : s2_r;
      m3_side_r <= m3_side_nxt;
    end
  end

  // Tangent product
  logic                        m4_v_r;
  logic [gae_pkg::PROD_W-1:0]  p4_r;
  logic [gae_pkg::SC_W-1:0]    den4_r;
  gae_pkg::side_t              m4_side_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m4_v_r <= 1'b0;
    end else if (ce) begin
      m4_v_r <= m3_v_r;
    end
    if (ce) begin
      p4_r      <= gae_pkg::PROD_W'(mul3_r) * gae_pkg::PROD_W'(num3_r);
      den4_r    <= den3_r;
      m4_side_r <= m3_side_r;
    end
  end

  // Tangent offset
  logic                          div_v;
  logic [gae_pkg::DIV_BITS-1:0]  div_d;
  gae_pkg::side_t                div_side;

  gae_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .ce       (ce),
    .in_v     (m4_v_r),
    .in_p     (p4_r),
    .in_den   (den4_r),
    .in_side  (m4_side_r),
    .out_v    (div_v),
    .out_d    (div_d),
    .out_side (div_side)
  );

  // Halve with round half up and saturate
  function automatic logic signed [gae_pkg::OUT_W-1:0] finish(
    input logic signed [25:0] v2);
    logic signed [25:0] v;
    logic signed [gae_pkg::OUT_W-1:0] r;
    v = (v2 + 26'sd1) >>> 1;
    if (v < -26'sd1048576) begin
      r = {1'b1, {(gae_pkg::OUT_W-1){1'b0}}};
    end else if (v > 26'sd1048575) begin
      r = {1'b0, {(gae_pkg::OUT_W-1){1'b1}}};
    end else begin
      r = v[gae_pkg::OUT_W-1:0];
    end
    return r;
  endfunction

  // Build the offsets and the two points
  gae_pkg::res_t      res_nxt;
  logic signed [24:0] ox, oy, wd, hd, dd;
  logic signed [25:0] cx2, cy2;

  always_comb begin
    wd = signed'({6'b0, div_side.w});
    hd = signed'({6'b0, div_side.h});
    dd = signed'({1'b0, div_d});
    if (!div_side.q[0]) begin
      if (div_side.below) begin
        ox = wd;  oy = -dd;
      end else begin
        ox = dd;  oy = -hd;
      end
    end else begin
      if (div_side.below) begin
        ox = -dd; oy = -hd;
      end else begin
        ox = -wd; oy = -dd;
      end
    end
    if (div_side.q[1]) begin
      ox = -ox; oy = -oy;
    end
    if (div_side.neg) begin
      ox = -ox; oy = -oy;
    end
    cx2 = signed'({{5{div_side.left[19]}}, div_side.left, 1'b0}) +
          signed'({7'b0, div_side.w});
    cy2 = signed'({{5{div_side.top[19]}}, div_side.top, 1'b0}) +
          signed'({7'b0, div_side.h});
    res_nxt.start_x = finish(cx2 + 26'(ox));
    res_nxt.start_y = finish(cy2 + 26'(oy));
    res_nxt.end_x   = finish(cx2 - 26'(ox));
    res_nxt.end_y   = finish(cy2 - 26'(oy));
  end

  // Last pipeline stage
  logic          fin_v_r;
  gae_pkg::res_t fin_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fin_v_r <= 1'b0;
    end else if (ce) begin
      fin_v_r <= div_v;
    end
    if (ce) begin
      fin_r <= res_nxt;
    end
  end

  // Output register with one-item skid stage
  logic          out_v_r, skid_v_r;
  gae_pkg::res_t out_r, skid_r;

  assign ce        = !skid_v_r;
  assign in_tready = ce;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else if (!out_v_r || out_tready) begin
      if (skid_v_r) begin
        out_v_r  <= 1'b1;
        skid_v_r <= 1'b0;
      end else begin
        out_v_r  <= fin_v_r;
      end
    end else if (fin_v_r && ce) begin
      skid_v_r <= 1'b1;
    end
    if (!out_v_r || out_tready) begin
      out_r <= skid_v_r ? skid_r : fin_r;
    end else if (fin_v_r && ce) begin
      skid_r <= fin_r;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = {4'b0, out_r.end_y, out_r.end_x, out_r.start_y, out_r.start_x};

endmodule
